// ----- rtl/csa_pkg.sv -----
// package for the contiguous slot allocator: field widths, stream widths,
// request kind codes and parameter defaults. no dependencies.
package csa_pkg;

  localparam int unsigned SlotsDef        = 512;
  localparam int unsigned FirstDynamicDef = 16;

  // run lengths and slot fields on the stream are 9 bits wide
  localparam int unsigned LenW = 9;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

endpackage

// ----- rtl/contiguous_slot_allocator.sv -----
// first-fit allocator of contiguous slot runs; run lengths held in one
// synchronous single-read memory. depends on csa_pkg.
//
// steps: allocate alternates scan and evaluate (one memory read and one evaluate
//   per visited run start or free slot); free reads, then clears the entry; bad requests go straight to output
// throughput: one item at a time, set by the probe loop over the memory
// reset: a clearing pass writes zero to all SLOTS entries, one per cycle,
//   so no item is taken until the clearing pass has ended
module contiguous_slot_allocator #(
  parameter int unsigned SLOTS         = csa_pkg::SlotsDef,
  parameter int unsigned FIRST_DYNAMIC = csa_pkg::FirstDynamicDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [8:0] request_count, [17:9] free_slot, [23:18] zero
  input  logic [csa_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] kind
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [8:0] granted_slot, [17:9] released_count, [18] success, [23:19] zero
  output logic [csa_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import csa_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  // wide enough for start + length past the table end
  localparam int unsigned PW = $clog2(SLOTS + 2 * (1 << LenW));

  localparam logic [PW-1:0] MaxWant  = PW'(SLOTS - 1 - FIRST_DYNAMIC);
  localparam logic [PW-1:0] LastSlot = PW'(SLOTS - 1);
  localparam logic [PW-1:0] NumSlots = PW'(SLOTS);
  localparam logic [PW-1:0] FirstDyn = PW'(FIRST_DYNAMIC);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [SW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [PW-1:0]   start_q, start_d;
  logic [PW-1:0]   probe_q, probe_d;
  logic [LenW-1:0] want_q, want_d;

  logic [LenW-1:0] res_slot_q, res_slot_d;
  logic [LenW-1:0] res_cnt_q, res_cnt_d;
  logic            res_ok_q, res_ok_d;

  logic            out_valid_q, out_valid_d;
  logic [LenW-1:0] out_slot_q, out_slot_d;
  logic [LenW-1:0] out_cnt_q, out_cnt_d;
  logic            out_ok_q, out_ok_d;

  logic            mem_we, mem_re;
  logic [SW-1:0]   mem_waddr, mem_raddr;
  logic [LenW-1:0] mem_wdata, mem_rdata_q;
  logic [LenW-1:0] mem [SLOTS];

  logic [LenW-1:0] in_want, in_slot;
  logic            in_kind, in_xfer, out_load;
  logic [PW-1:0]   run_end;

  assign in_want = s_axis_tdata_i[LenW-1:0];
  assign in_slot = s_axis_tdata_i[2*LenW-1:LenW];
  assign in_kind = s_axis_tuser_i;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign run_end         = start_q + PW'(want_q);
  assign out_load        = (state_q == S_OUT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    start_d    = start_q;
    probe_d    = probe_q;
    want_d     = want_q;
    res_slot_d = res_slot_q;
    res_cnt_d  = res_cnt_q;
    res_ok_d   = res_ok_q;
    mem_we     = 1'b0;
    mem_waddr  = start_q[SW-1:0];
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = probe_q[SW-1:0];

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastSlot[SW-1:0]) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          res_slot_d = '0;
          res_cnt_d  = '0;
          res_ok_d   = 1'b0;
          want_d     = in_want;
          if (in_kind == KindFree) begin
            start_d = PW'(in_slot);
            if (PW'(in_slot) < NumSlots) begin
              mem_re    = 1'b1;
              mem_raddr = SW'(in_slot);
              state_d   = S_FREE;
            end else begin
              state_d = S_OUT;
            end
          end else if (in_want == '0 || PW'(in_want) > MaxWant) begin
            state_d = S_OUT;
          end else begin
            start_d = FirstDyn;
            probe_d = FirstDyn;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (probe_q >= run_end) begin
          mem_we     = 1'b1;
          mem_wdata  = want_q;
          res_slot_d = start_q[LenW-1:0];
          res_ok_d   = 1'b1;
          state_d    = S_OUT;
        end else if (probe_q > LastSlot) begin
          state_d = S_OUT;
        end else begin
          mem_re  = 1'b1;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        // a used run start: jump past the run
        if (mem_rdata_q != '0) begin
          start_d = probe_q + PW'(mem_rdata_q);
          probe_d = probe_q + PW'(mem_rdata_q);
        end else begin
          probe_d = probe_q + 1'b1;
        end
        state_d = S_SCAN;
      end
      S_FREE: begin
        mem_we    = 1'b1;
        res_cnt_d = mem_rdata_q;
        res_ok_d  = (mem_rdata_q != '0);
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_cnt_d   = out_cnt_q;
    out_ok_d    = out_ok_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_slot_d  = res_slot_q;
      out_cnt_d   = res_cnt_q;
      out_ok_d    = res_ok_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    probe_q    <= probe_d;
    want_q     <= want_d;
    res_slot_q <= res_slot_d;
    res_cnt_q  <= res_cnt_d;
    res_ok_q   <= res_ok_d;
    out_slot_q <= out_slot_d;
    out_cnt_q  <= out_cnt_d;
    out_ok_q   <= out_ok_d;
  end

  // run length memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - 2 * LenW - 1)'(0), out_ok_q, out_cnt_q, out_slot_q};

  // a grant is only written at a start inside the table
  a_grant_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_we) |-> (start_q < NumSlots))
    else $error("grant written beyond table end");

  // the probe always moves forward after an evaluate
  a_probe_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |=> (probe_q > $past(probe_q)))
    else $error("scan probe did not advance");

  // the clearing pass leaves only after the last entry
  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && state_d != S_CLEAR) |-> (clr_cnt_q == LastSlot[SW-1:0]))
    else $error("clearing pass ended early");

  // a failed item reports no slot and no count
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ok_q) |-> (out_slot_q == '0 && out_cnt_q == '0))
    else $error("failed result carries nonzero fields");

  // a memory read is never issued in the same cycle as a write
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> !mem_we)
    else $error("memory read and write overlap");

endmodule
